[rtl/ambient_brightness_fader_core_macros.svh]
// Assertion macros for the ambient brightness fader checker.
// Expects signals named clock and reset in the scope of use.
`ifndef AMBIENT_BRIGHTNESS_FADER_CORE_MACROS_SVH
`define AMBIENT_BRIGHTNESS_FADER_CORE_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define ABF_ASSERT_ALWAYS(label, cond) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("abf check failed");

// Same-cycle implication
`define ABF_ASSERT_IMP(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("abf check failed");

// Next-cycle implication
`define ABF_ASSERT_NXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("abf check failed");

`endif

[rtl/abf_pkg.sv]
// Package for the ambient brightness fader: widths, codes, types and helpers.
// Used by the interfaces, modules and testbench of the block; depends on nothing.
package abf_pkg;

   localparam int CMD_W            = 2;
   localparam int LIGHT_W          = 12;
   localparam int LEVEL_W          = 8;
   localparam int INTERVAL_W       = 16;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;
   localparam int PROD_W           = LIGHT_W + LEVEL_W;
   localparam int DIV_STEPS        = LEVEL_W;
   localparam int DIV_CNT_W        = $clog2(DIV_STEPS);
   localparam int BRIGHT_FULL_DEF  = 255;
   localparam int SENSOR_BITS_DEF  = 12;

   typedef enum logic [CMD_W-1:0] {
      CMD_TICK       = 2'd0,
      CMD_SET_NOW    = 2'd1,
      CMD_SET_TARGET = 2'd2,
      CMD_START      = 2'd3
   } cmd_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BRIGHT_MIN       = 3'd0,
      CSR_FADE_INTERVAL    = 3'd1,
      CSR_FADE_STEP        = 3'd2,
      CSR_LUX_DEADBAND     = 3'd3,
      CSR_SENSOR_FLOOR     = 3'd4,
      CSR_SENSOR_CEILING   = 3'd5,
      CSR_AMBIENT_INTERVAL = 3'd6,
      CSR_TARGET_THRESHOLD = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0]    bright_min;
      logic [INTERVAL_W-1:0] fade_interval_ms;
      logic [LEVEL_W-1:0]    fade_step;
      logic [LIGHT_W-1:0]    lux_deadband;
      logic [LIGHT_W-1:0]    sensor_floor;
      logic [LIGHT_W-1:0]    sensor_ceiling;
      logic [INTERVAL_W-1:0] ambient_interval_ms;
      logic [LEVEL_W-1:0]    target_threshold;
   } cfg_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MULT,
      ST_DIV,
      ST_ADOPT,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic accept;
      logic prep;
      logic mult;
      logic div_step;
      logic adopt;
      logic emit;
   } ctrl_cmd_type;

   typedef struct packed {
      logic amb_go;
      logic out_free;
   } dp_status_type;

   // Raise a nonzero level below the minimum to the minimum
   function automatic logic [LEVEL_W-1:0] raise_level(input logic [LEVEL_W-1:0] lv,
                                                      input logic [LEVEL_W-1:0] bmin);
      return ((lv != '0) && (lv < bmin)) ? bmin : lv;
   endfunction

endpackage

[rtl/abf_if.sv]
// Channel interfaces of the ambient brightness fader: request, result, CSR write.
// Depends on abf_pkg for field widths.
interface abf_req_if;
   logic                              valid;
   logic                              ready;
   logic [abf_pkg::CMD_W-1:0]         cmd;
   logic [abf_pkg::LIGHT_W-1:0]       light_sample;
   logic [abf_pkg::LEVEL_W-1:0]       level;

   modport source (output valid, output cmd, output light_sample, output level,
                   input ready);
   modport sink   (input valid, input cmd, input light_sample, input level,
                   output ready);
endinterface

interface abf_rsp_if;
   logic                              valid;
   logic                              ready;
   logic [abf_pkg::LEVEL_W-1:0]       duty;
   logic [abf_pkg::LEVEL_W-1:0]       target_level;
   logic                              fading;

   modport source (output valid, output duty, output target_level, output fading,
                   input ready);
   modport sink   (input valid, input duty, input target_level, input fading,
                   output ready);
endinterface

interface abf_csr_if;
   logic                              valid;
   logic                              ready;
   logic [abf_pkg::CSR_IDX_W-1:0]     index;
   logic [abf_pkg::CSR_DATA_W-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/abf_csr.sv]
// Configuration register file of the ambient brightness fader.
// Depends on abf_pkg for the register codes and the cfg_type bundle.
module abf_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           wr_valid,
   input  logic [abf_pkg::CSR_IDX_W-1:0]  wr_index,
   input  logic [abf_pkg::CSR_DATA_W-1:0] wr_data,
   output logic                           wr_ready,
   output abf_pkg::cfg_type               cfg
);

   abf_pkg::cfg_type cfg_ff;
   abf_pkg::cfg_type cfg_in;

   assign wr_ready = 1'b1;
   assign cfg      = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_valid) begin
         unique case (abf_pkg::csr_index_type'(wr_index))
            abf_pkg::CSR_BRIGHT_MIN:
               cfg_in.bright_min = wr_data[abf_pkg::LEVEL_W-1:0];
            abf_pkg::CSR_FADE_INTERVAL:
               cfg_in.fade_interval_ms = wr_data[abf_pkg::INTERVAL_W-1:0];
            abf_pkg::CSR_FADE_STEP:
               cfg_in.fade_step = wr_data[abf_pkg::LEVEL_W-1:0];
            abf_pkg::CSR_LUX_DEADBAND:
               cfg_in.lux_deadband = wr_data[abf_pkg::LIGHT_W-1:0];
            abf_pkg::CSR_SENSOR_FLOOR:
               cfg_in.sensor_floor = wr_data[abf_pkg::LIGHT_W-1:0];
            abf_pkg::CSR_SENSOR_CEILING:
               cfg_in.sensor_ceiling = wr_data[abf_pkg::LIGHT_W-1:0];
            abf_pkg::CSR_AMBIENT_INTERVAL:
               cfg_in.ambient_interval_ms = wr_data[abf_pkg::INTERVAL_W-1:0];
            abf_pkg::CSR_TARGET_THRESHOLD:
               cfg_in.target_threshold = wr_data[abf_pkg::LEVEL_W-1:0];
            default: cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.bright_min          <= abf_pkg::LEVEL_W'(10);
         cfg_ff.fade_interval_ms    <= abf_pkg::INTERVAL_W'(20);
         cfg_ff.fade_step           <= abf_pkg::LEVEL_W'(5);
         cfg_ff.lux_deadband        <= abf_pkg::LIGHT_W'(50);
         cfg_ff.sensor_floor        <= '0;
         cfg_ff.sensor_ceiling      <= '1;
         cfg_ff.ambient_interval_ms <= abf_pkg::INTERVAL_W'(1000);
         cfg_ff.target_threshold    <= abf_pkg::LEVEL_W'(5);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

[rtl/abf_ctrl.sv]
// Controller of the ambient brightness fader: sequences accept, map, divide, emit.
// Depends on abf_pkg for the state, command and status types.
module abf_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  abf_pkg::dp_status_type status,
   output abf_pkg::ctrl_cmd_type  ctrl
);

   abf_pkg::state_type             state_ff;
   abf_pkg::state_type             state_in;
   logic [abf_pkg::DIV_CNT_W-1:0]  cnt_ff;
   logic [abf_pkg::DIV_CNT_W-1:0]  cnt_in;
   logic                           last_step;

   assign last_step = (cnt_ff == abf_pkg::DIV_CNT_W'(abf_pkg::DIV_STEPS - 1));

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         abf_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = status.amb_go ? abf_pkg::ST_PREP : abf_pkg::ST_EMIT;
            end
         end
         abf_pkg::ST_PREP:  state_in = abf_pkg::ST_MULT;
         abf_pkg::ST_MULT:  state_in = abf_pkg::ST_DIV;
         abf_pkg::ST_DIV: begin
            if (last_step) begin
               state_in = abf_pkg::ST_ADOPT;
            end
         end
         abf_pkg::ST_ADOPT: state_in = abf_pkg::ST_EMIT;
         abf_pkg::ST_EMIT: begin
            if (status.out_free) begin
               state_in = abf_pkg::ST_IDLE;
            end
         end
         default: state_in = abf_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      ctrl      = '0;
      req_ready = 1'b0;
      cnt_in    = '0;
      unique case (state_ff)
         abf_pkg::ST_IDLE: begin
            req_ready   = 1'b1;
            ctrl.accept = req_valid;
         end
         abf_pkg::ST_PREP:  ctrl.prep = 1'b1;
         abf_pkg::ST_MULT:  ctrl.mult = 1'b1;
         abf_pkg::ST_DIV: begin
            ctrl.div_step = 1'b1;
            cnt_in        = cnt_ff + 1'b1;
         end
         abf_pkg::ST_ADOPT: ctrl.adopt = 1'b1;
         abf_pkg::ST_EMIT:  ctrl.emit  = status.out_free;
         default: ctrl = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= abf_pkg::ST_IDLE;
         cnt_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
   end

endmodule

[rtl/abf_dp.sv]
// Datapath of the ambient brightness fader: levels, counters, mapping, result word.
// Depends on abf_pkg; driven by abf_ctrl commands and configured by abf_csr.
module abf_dp #(
   parameter int BRIGHT_FULL = abf_pkg::BRIGHT_FULL_DEF,
   parameter int SENSOR_BITS = abf_pkg::SENSOR_BITS_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  abf_pkg::cfg_type              cfg,
   input  abf_pkg::ctrl_cmd_type         ctrl,
   output abf_pkg::dp_status_type        status,
   input  logic [abf_pkg::CMD_W-1:0]     req_cmd,
   input  logic [abf_pkg::LIGHT_W-1:0]   req_light,
   input  logic [abf_pkg::LEVEL_W-1:0]   req_level,
   input  logic                          rsp_ready,
   output logic                          rsp_valid,
   output logic [abf_pkg::LEVEL_W-1:0]   rsp_duty,
   output logic [abf_pkg::LEVEL_W-1:0]   rsp_target,
   output logic                          rsp_fading
);

   localparam int LW = abf_pkg::LEVEL_W;
   localparam int SW = abf_pkg::LIGHT_W;
   localparam int IW = abf_pkg::INTERVAL_W;
   localparam int PW = abf_pkg::PROD_W;
   localparam int MASK_BITS = (SENSOR_BITS < SW) ? SENSOR_BITS : SW;
   localparam logic [SW-1:0] SAMPLE_MASK = SW'((32'd1 << MASK_BITS) - 32'd1);
   localparam logic [LW-1:0] FULL = LW'(BRIGHT_FULL);

   logic [LW-1:0] cur_ff, cur_in, goal_ff, goal_in;
   logic [SW-1:0] acc_light_ff, acc_light_in, light_ff, light_in;
   logic [IW-1:0] fade_el_ff, fade_el_in, amb_el_ff, amb_el_in;
   logic [SW-1:0] diff_ff, diff_in, span_ff, span_in;
   logic [LW-1:0] mag_ff, mag_in;
   logic          neg_ff, neg_in, zero_ff, zero_in, inv_ff, inv_in;
   logic [PW-1:0] dvd_ff, dvd_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic [LW-1:0] duty_ff, duty_in, target_ff, target_in;
   logic          fading_ff, fading_in;

   logic [SW-1:0] sample, light_dev, sel_light, clamp_lo, clamped;
   logic          keep;
   logic [IW-1:0] fe_inc, ae_inc;
   logic          fade_go, amb_due, up;
   logic [LW-1:0] fade_gap, stepv, stepped, quot, mapped, nt, nt_dist;
   logic [SW:0]   shifted, shift_sub;
   logic          ge;

   always_comb begin
      sample    = req_light & SAMPLE_MASK;
      light_dev = (sample > acc_light_ff) ? sample - acc_light_ff : acc_light_ff - sample;
      keep      = light_dev < cfg.lux_deadband;
      sel_light = keep ? acc_light_ff : sample;

      fe_inc   = (fade_el_ff == '1) ? fade_el_ff : fade_el_ff + 1'b1;
      ae_inc   = (amb_el_ff == '1) ? amb_el_ff : amb_el_ff + 1'b1;
      fade_go  = (fe_inc >= cfg.fade_interval_ms) && (cur_ff != goal_ff);
      amb_due  = ae_inc >= cfg.ambient_interval_ms;
      up       = cur_ff < goal_ff;
      fade_gap = up ? goal_ff - cur_ff : cur_ff - goal_ff;
      stepv    = (cfg.fade_step < fade_gap) ? cfg.fade_step : fade_gap;
      stepped  = up ? cur_ff + stepv : cur_ff - stepv;

      clamp_lo = (light_ff < cfg.sensor_floor) ? cfg.sensor_floor : light_ff;
      clamped  = (clamp_lo > cfg.sensor_ceiling) ? cfg.sensor_ceiling : clamp_lo;

      shifted   = {dvd_ff[PW-1:LW], dvd_ff[LW-1]};
      ge        = shifted >= {1'b0, span_ff};
      shift_sub = ge ? shifted - {1'b0, span_ff} : shifted;

      quot    = dvd_ff[LW-1:0];
      mapped  = neg_ff ? cfg.bright_min - quot : cfg.bright_min + quot;
      nt      = inv_ff ? FULL : (zero_ff ? cfg.bright_min : mapped);
      nt_dist = (nt > goal_ff) ? nt - goal_ff : goal_ff - nt;
   end

   assign status.amb_go   = (abf_pkg::cmd_type'(req_cmd) == abf_pkg::CMD_TICK) && amb_due;
   assign status.out_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      cur_in       = cur_ff;
      goal_in      = goal_ff;
      acc_light_in = acc_light_ff;
      light_in     = light_ff;
      fade_el_in   = fade_el_ff;
      amb_el_in    = amb_el_ff;
      if (ctrl.accept) begin
         unique case (abf_pkg::cmd_type'(req_cmd))
            abf_pkg::CMD_TICK: begin
               fade_el_in = fade_go ? '0 : fe_inc;
               cur_in     = fade_go ? stepped : cur_ff;
               amb_el_in  = amb_due ? '0 : ae_inc;
               if (amb_due) begin
                  light_in     = sel_light;
                  acc_light_in = sel_light;
               end
            end
            abf_pkg::CMD_SET_NOW: begin
               cur_in  = abf_pkg::raise_level(req_level, cfg.bright_min);
               goal_in = abf_pkg::raise_level(req_level, cfg.bright_min);
            end
            abf_pkg::CMD_SET_TARGET: begin
               goal_in = abf_pkg::raise_level(req_level, cfg.bright_min);
            end
            abf_pkg::CMD_START: begin
               cur_in       = abf_pkg::raise_level(FULL, cfg.bright_min);
               goal_in      = abf_pkg::raise_level(FULL, cfg.bright_min);
               acc_light_in = sample;
            end
            default: cur_in = cur_ff;
         endcase
      end
      if (ctrl.adopt && (nt_dist > cfg.target_threshold)) begin
         goal_in = abf_pkg::raise_level(nt, cfg.bright_min);
      end
   end

   always_comb begin
      diff_in = diff_ff;
      span_in = span_ff;
      mag_in  = mag_ff;
      neg_in  = neg_ff;
      zero_in = zero_ff;
      inv_in  = inv_ff;
      dvd_in  = dvd_ff;
      if (ctrl.prep) begin
         diff_in = clamped - cfg.sensor_floor;
         span_in = cfg.sensor_ceiling - cfg.sensor_floor;
         neg_in  = cfg.bright_min > FULL;
         mag_in  = (cfg.bright_min > FULL) ? cfg.bright_min - FULL : FULL - cfg.bright_min;
         zero_in = cfg.sensor_floor == cfg.sensor_ceiling;
         inv_in  = cfg.sensor_floor > cfg.sensor_ceiling;
      end
      if (ctrl.mult) begin
         dvd_in = PW'(diff_ff) * PW'(mag_ff);
      end
      if (ctrl.div_step) begin
         dvd_in = {shift_sub[SW-1:0], dvd_ff[LW-2:0], ge};
      end
   end

   always_comb begin
      duty_in      = duty_ff;
      target_in    = target_ff;
      fading_in    = fading_ff;
      rsp_valid_in = rsp_ready ? 1'b0 : rsp_valid_ff;
      if (ctrl.emit) begin
         duty_in      = cur_ff;
         target_in    = goal_ff;
         fading_in    = cur_ff != goal_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff       <= FULL;
         goal_ff      <= FULL;
         acc_light_ff <= '0;
         fade_el_ff   <= '1;
         amb_el_ff    <= '1;
         rsp_valid_ff <= 1'b0;
      end else begin
         cur_ff       <= cur_in;
         goal_ff      <= goal_in;
         acc_light_ff <= acc_light_in;
         fade_el_ff   <= fade_el_in;
         amb_el_ff    <= amb_el_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      light_ff  <= light_in;
      diff_ff   <= diff_in;
      span_ff   <= span_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      zero_ff   <= zero_in;
      inv_ff    <= inv_in;
      dvd_ff    <= dvd_in;
      duty_ff   <= duty_in;
      target_ff <= target_in;
      fading_ff <= fading_in;
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty   = duty_ff;
   assign rsp_target = target_ff;
   assign rsp_fading = fading_ff;

endmodule

[rtl/ambient_brightness_fader_core.sv]
// Top level of the ambient brightness fader: controller, datapath and CSR file.
// Depends on abf_pkg, abf_if, abf_csr, abf_ctrl and abf_dp.
//
//   channel   direction  word
//   req_if    in         cmd, light_sample, level
//   rsp_if    out        duty, target_level, fading
//   csr_if    in         index, data (always ready)
//
// One word at a time: set, target, start and ticks without an ambient
// evaluation go from accept straight to emit; a tick that runs the ambient
// evaluation first passes prep, multiply, eight-step restoring divide, adopt.
// Synchronous active-high reset loads full brightness and saturated counters.
// A stalled result holds in the output register; the next word is accepted
// meanwhile and waits in the emit step until that register frees.
module ambient_brightness_fader_core #(
   parameter int BRIGHT_FULL = abf_pkg::BRIGHT_FULL_DEF,
   parameter int SENSOR_BITS = abf_pkg::SENSOR_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   abf_req_if.sink   req_if,
   abf_rsp_if.source rsp_if,
   abf_csr_if.sink   csr_if
);

   abf_pkg::cfg_type       cfg;
   abf_pkg::ctrl_cmd_type  ctrl;
   abf_pkg::dp_status_type status;

   abf_csr u_csr (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (csr_if.valid),
      .wr_index (csr_if.index),
      .wr_data  (csr_if.data),
      .wr_ready (csr_if.ready),
      .cfg      (cfg)
   );

   abf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .ctrl      (ctrl)
   );

   abf_dp #(
      .BRIGHT_FULL (BRIGHT_FULL),
      .SENSOR_BITS (SENSOR_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg),
      .ctrl       (ctrl),
      .status     (status),
      .req_cmd    (req_if.cmd),
      .req_light  (req_if.light_sample),
      .req_level  (req_if.level),
      .rsp_ready  (rsp_if.ready),
      .rsp_valid  (rsp_if.valid),
      .rsp_duty   (rsp_if.duty),
      .rsp_target (rsp_if.target_level),
      .rsp_fading (rsp_if.fading)
   );

endmodule

[rtl/abf_checker.sv]
// Port-level checks for the ambient brightness fader, bound to the top level.
// Depends on abf_pkg and ambient_brightness_fader_core_macros.svh.
`include "ambient_brightness_fader_core_macros.svh"

module abf_checker (
   input logic                         clock,
   input logic                         reset,
   input logic                         req_valid,
   input logic                         req_ready,
   input logic                         rsp_valid,
   input logic                         rsp_ready,
   input logic [abf_pkg::LEVEL_W-1:0]  rsp_duty,
   input logic [abf_pkg::LEVEL_W-1:0]  rsp_target,
   input logic                         rsp_fading
);

   `ABF_ASSERT_IMP(a_ready_drops_on_accept, $fell(req_ready), $past(req_valid))
   `ABF_ASSERT_IMP(a_result_after_busy, $rose(rsp_valid), !$past(req_ready))
   `ABF_ASSERT_IMP(a_fading_matches, rsp_valid, rsp_fading == (rsp_duty != rsp_target))
   `ABF_ASSERT_NXT(a_stalled_word_holds, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_duty) && $stable(rsp_target) && $stable(rsp_fading))

endmodule

bind ambient_brightness_fader_core abf_checker u_abf_checker (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_if.valid),
   .req_ready  (req_if.ready),
   .rsp_valid  (rsp_if.valid),
   .rsp_ready  (rsp_if.ready),
   .rsp_duty   (rsp_if.duty),
   .rsp_target (rsp_if.target_level),
   .rsp_fading (rsp_if.fading)
);

[tb/ambient_brightness_fader_core_tb.sv]
// Self-checking testbench for ambient_brightness_fader_core: a scoreboard class predicts
// each result word, tasks drive the request and CSR channels, random ready stalls rsp_if.
// Depends on abf_pkg, abf_if and the RTL of the block.
`timescale 1ns / 1ps

module ambient_brightness_fader_core_tb;
   import abf_pkg::*;

   localparam int FULL_LEVEL    = BRIGHT_FULL_DEF;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = 20;
   localparam int PHASE_WORDS   = 200;

   typedef struct packed {
      logic [LEVEL_W-1:0] duty;
      logic [LEVEL_W-1:0] target_level;
      logic               fading;
   } fader_word_type;

   class brightness_scoreboard_type;
      logic [LEVEL_W-1:0]    bright_min, fade_step, threshold;
      logic [INTERVAL_W-1:0] fade_interval, ambient_interval;
      logic [LIGHT_W-1:0]    hysteresis, floor_lim, ceil_lim;
      logic [LEVEL_W-1:0]    duty_now, goal;
      logic [LIGHT_W-1:0]    light_ref;
      logic [INTERVAL_W-1:0] fade_count, ambient_count;
      fader_word_type        expected_words[$];
      int                    errors;
      int                    checked;

      function new();
         bright_min       = 8'd10;
         fade_interval    = 16'd20;
         fade_step        = 8'd5;
         hysteresis       = 12'd50;
         floor_lim        = 12'd0;
         ceil_lim         = 12'd4095;
         ambient_interval = 16'd1000;
         threshold        = 8'd5;
         duty_now         = LEVEL_W'(FULL_LEVEL);
         goal             = LEVEL_W'(FULL_LEVEL);
         light_ref        = '0;
         fade_count       = '1;
         ambient_count    = '1;
         errors           = 0;
         checked          = 0;
      endfunction

      function void set_reg(csr_index_type idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_BRIGHT_MIN:       bright_min       = data[LEVEL_W-1:0];
            CSR_FADE_INTERVAL:    fade_interval    = data[INTERVAL_W-1:0];
            CSR_FADE_STEP:        fade_step        = data[LEVEL_W-1:0];
            CSR_LUX_DEADBAND:     hysteresis       = data[LIGHT_W-1:0];
            CSR_SENSOR_FLOOR:     floor_lim        = data[LIGHT_W-1:0];
            CSR_SENSOR_CEILING:   ceil_lim         = data[LIGHT_W-1:0];
            CSR_AMBIENT_INTERVAL: ambient_interval = data[INTERVAL_W-1:0];
            default:              threshold        = data[LEVEL_W-1:0];
         endcase
      endfunction

      function logic [LEVEL_W-1:0] lift(logic [LEVEL_W-1:0] lv);
         return ((lv != '0) && (lv < bright_min)) ? bright_min : lv;
      endfunction

      function logic [LEVEL_W-1:0] map_light(logic [LIGHT_W-1:0] s_in);
         logic [LIGHT_W-1:0] s, diff;
         int light, lo, hi, span_in, span_out, bmin, r;
         s    = s_in;
         diff = (s > light_ref) ? s - light_ref : light_ref - s;
         if (diff < hysteresis) s = light_ref;
         else light_ref = s;
         light = int'(s);
         lo    = int'(floor_lim);
         hi    = int'(ceil_lim);
         bmin  = int'(bright_min);
         if (light < lo) light = lo;
         if (light > hi) light = hi;
         span_in = hi - lo;
         if (span_in == 0) return bright_min;
         span_out = FULL_LEVEL - bmin;
         r = (light - lo) * span_out / span_in + bmin;
         return r[LEVEL_W-1:0];
      endfunction

      function void tick(logic [LIGHT_W-1:0] s);
         logic [LEVEL_W-1:0] gap, stride, nt, d;
         if (fade_count != '1) fade_count++;
         if (ambient_count != '1) ambient_count++;
         if (fade_count >= fade_interval && duty_now != goal) begin
            gap      = (duty_now < goal) ? goal - duty_now : duty_now - goal;
            stride   = (fade_step < gap) ? fade_step : gap;
            duty_now = (duty_now < goal) ? duty_now + stride : duty_now - stride;
            fade_count = '0;
         end
         if (ambient_count >= ambient_interval) begin
            nt = map_light(s);
            d  = (nt > goal) ? nt - goal : goal - nt;
            if (d > threshold) goal = lift(nt);
            ambient_count = '0;
         end
      endfunction

      function void note_command(cmd_type c, logic [LIGHT_W-1:0] s, logic [LEVEL_W-1:0] lv);
         fader_word_type w;
         case (c)
            CMD_TICK: tick(s);
            CMD_SET_NOW: begin
               duty_now = lift(lv);
               goal     = duty_now;
            end
            CMD_SET_TARGET: goal = lift(lv);
            default: begin
               duty_now  = lift(LEVEL_W'(FULL_LEVEL));
               goal      = duty_now;
               light_ref = s;
            end
         endcase
         w.duty         = duty_now;
         w.target_level = goal;
         w.fading       = (duty_now != goal);
         expected_words.push_back(w);
      endfunction

      function int pending();
         return expected_words.size();
      endfunction

      task report_mismatch(string msg);
         $display("ERROR at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check_result(logic [LEVEL_W-1:0] duty, logic [LEVEL_W-1:0] tgt, logic fading);
         fader_word_type want;
         if (expected_words.size() == 0) begin
            report_mismatch($sformatf("result word with none expected (duty %0d)", duty));
         end else begin
            want = expected_words.pop_front();
            if (duty !== want.duty)
               report_mismatch($sformatf("word %0d duty %0d, want %0d",
                                         checked, duty, want.duty));
            if (tgt !== want.target_level)
               report_mismatch($sformatf("word %0d target_level %0d, want %0d",
                                         checked, tgt, want.target_level));
            if (fading !== want.fading)
               report_mismatch($sformatf("word %0d fading %0b, want %0b",
                                         checked, fading, want.fading));
            checked++;
         end
      endtask
   endclass

   logic clock;
   logic reset;

   abf_req_if req_if();
   abf_rsp_if rsp_if();
   abf_csr_if csr_if();

   ambient_brightness_fader_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_if),
      .rsp_if (rsp_if),
      .csr_if (csr_if)
   );

   brightness_scoreboard_type sb;
   int send_idle_pct;
   int recv_stall_pct;
   int quiet_cycles;
   int n_sent;
   int n_ticks;
   int n_random;
   int n_settings;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_if.ready <= 1'b0;
      else
         rsp_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_if.valid && rsp_if.ready)
         sb.check_result(rsp_if.duty, rsp_if.target_level, rsp_if.fading);
   end

   always @(posedge clock) begin
      if (reset || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
          (csr_if.valid && csr_if.ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("Watchdog: no word moved for %0d cycles", STALL_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end
   end

   task automatic send_word(input cmd_type c, input logic [LIGHT_W-1:0] s,
                            input logic [LEVEL_W-1:0] lv);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(0, 99) < send_idle_pct);
      end
      req_if.valid        <= 1'b1;
      req_if.cmd          <= c;
      req_if.light_sample <= s;
      req_if.level        <= lv;
      do @(posedge clock); while (!req_if.ready);
      sb.note_command(c, s, lv);
      n_sent++;
      if (c == CMD_TICK) n_ticks++;
   endtask

   // hold the sender until every expected word is back
   task automatic drain();
      req_if.valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] data);
      csr_if.valid <= 1'b1;
      csr_if.index <= idx;
      csr_if.data  <= data;
      do @(posedge clock); while (!csr_if.ready);
      sb.set_reg(idx, data);
   endtask

   // stray upper bits must be dropped by the block
   function automatic logic [CSR_DATA_W-1:0] csr_word(input int value, input int width);
      logic [CSR_DATA_W-1:0] w;
      w = value[CSR_DATA_W-1:0];
      if (width < CSR_DATA_W && $urandom_range(0, 3) == 0)
         w = w | CSR_DATA_W'($urandom() << width);
      return w;
   endfunction

   task automatic apply_settings(input int bmin, input int fint, input int fstep,
                                 input int hyst, input int flo, input int fceil,
                                 input int aint, input int thr);
      write_reg(CSR_BRIGHT_MIN,       csr_word(bmin,  LEVEL_W));
      write_reg(CSR_FADE_INTERVAL,    csr_word(fint,  INTERVAL_W));
      write_reg(CSR_FADE_STEP,        csr_word(fstep, LEVEL_W));
      write_reg(CSR_LUX_DEADBAND,     csr_word(hyst,  LIGHT_W));
      write_reg(CSR_SENSOR_FLOOR,     csr_word(flo,   LIGHT_W));
      write_reg(CSR_SENSOR_CEILING,   csr_word(fceil, LIGHT_W));
      write_reg(CSR_AMBIENT_INTERVAL, csr_word(aint,  INTERVAL_W));
      write_reg(CSR_TARGET_THRESHOLD, csr_word(thr,   LEVEL_W));
      csr_if.valid <= 1'b0;
      n_settings++;
   endtask

   task automatic random_settings();
      int lo, hi, t;
      lo = $urandom_range(0, 4095);
      hi = $urandom_range(0, 4095);
      if (lo > hi && $urandom_range(0, 3) != 0) begin
         t  = lo;
         lo = hi;
         hi = t;
      end
      apply_settings(($urandom_range(0, 3) == 0) ? $urandom_range(0, 255) : $urandom_range(0, 40),
                     $urandom_range(0, 4),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : $urandom_range(1, 12),
                     $urandom_range(0, 400), lo, hi,
                     $urandom_range(0, 6), $urandom_range(0, 30));
   endtask

   task automatic random_word();
      cmd_type            c;
      logic [LIGHT_W-1:0] s;
      logic [LEVEL_W-1:0] lv;
      int                 pick, near, h;
      if (n_random < 633) begin
         send_idle_pct  = 15;
         recv_stall_pct = 66;
      end else if (n_random < 1266) begin
         send_idle_pct  = 66;
         recv_stall_pct = 15;
      end else begin
         send_idle_pct  = 0;
         recv_stall_pct = 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 72) c = CMD_TICK;
      else if (pick < 82) c = CMD_SET_NOW;
      else if (pick < 92) c = CMD_SET_TARGET;
      else c = CMD_START;
      case ($urandom_range(0, 9))
         0: s = '0;
         1: s = '1;
         2, 3, 4: begin
            h    = int'(sb.hysteresis) + 1;
            near = int'(sb.light_ref) + $urandom_range(0, 2 * h) - h;
            if (near < 0) near = 0;
            if (near > 4095) near = 4095;
            s = near[LIGHT_W-1:0];
         end
         default: s = LIGHT_W'($urandom_range(0, 4095));
      endcase
      case ($urandom_range(0, 7))
         0:       lv = '0;
         1:       lv = LEVEL_W'($urandom_range(0, sb.bright_min));
         2:       lv = '1;
         default: lv = LEVEL_W'($urandom_range(0, 255));
      endcase
      if ($urandom_range(0, 199) == 0) drain();
      send_word(c, s, lv);
      n_random++;
   endtask

   initial begin
      sb             = new();
      send_idle_pct  = 15;
      recv_stall_pct = 66;
      n_sent         = 0;
      n_ticks        = 0;
      n_random       = 0;
      n_settings     = 1;
      reset               <= 1'b1;
      req_if.valid        <= 1'b0;
      req_if.cmd          <= CMD_TICK;
      req_if.light_sample <= '0;
      req_if.level        <= '0;
      csr_if.valid        <= 1'b0;
      csr_if.index        <= CSR_BRIGHT_MIN;
      csr_if.data         <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // reset settings: saturated counters, level raise, start priming
      send_word(CMD_TICK,       12'd0,    8'd0);
      send_word(CMD_TICK,       12'd4095, 8'd0);
      send_word(CMD_TICK,       12'd0,    8'd255);
      send_word(CMD_SET_NOW,    12'd0,    8'd0);
      send_word(CMD_SET_NOW,    12'd0,    8'd5);
      send_word(CMD_SET_NOW,    12'd4095, 8'd255);
      send_word(CMD_SET_TARGET, 12'd0,    8'd0);
      send_word(CMD_SET_TARGET, 12'd0,    8'd3);
      send_word(CMD_SET_TARGET, 12'd0,    8'd200);
      send_word(CMD_START,      12'd4095, 8'd0);
      send_word(CMD_START,      12'd0,    8'd0);
      send_word(CMD_SET_NOW,    12'd0,    8'd9);
      send_word(CMD_SET_NOW,    12'd0,    8'd10);
      send_word(CMD_TICK,       12'd2048, 8'd0);
      send_word(CMD_SET_TARGET, 12'd0,    8'd1);
      send_word(CMD_TICK,       12'd4095, 8'd0);
      send_word(CMD_TICK,       12'd4095, 8'd0);
      send_word(CMD_TICK,       12'd1234, 8'd77);
      for (int k = 0; k < 100; k++) random_word();

      for (int p = 1; p <= 9; p++) begin
         drain();
         case (p)
            1: apply_settings(0, 0, 255, 0, 0, 4095, 0, 0);
            2: apply_settings(255, 65535, 1, 4095, 0, 4095, 65535, 255);
            // zero-width sensor window
            3: apply_settings(20, 1, 3, 100, 2000, 2000, 0, 2);
            // inverted window with a zero fade step
            4: apply_settings(30, 0, 0, 10, 4095, 0, 1, 0);
            default: random_settings();
         endcase
         for (int k = 0; k < PHASE_WORDS; k++) random_word();
      end

      drain();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Sent %0d command words (%0d ticks) across %0d register settings;",
               n_sent, n_ticks, n_settings);
      $display("compared %0d result words, %0d mismatches.", sb.checked, sb.errors);
      if (sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

[filelist.f]
+incdir+rtl
rtl/abf_pkg.sv
rtl/abf_if.sv
rtl/abf_csr.sv
rtl/abf_ctrl.sv
rtl/abf_dp.sv
rtl/ambient_brightness_fader_core.sv
rtl/abf_checker.sv
tb/ambient_brightness_fader_core_tb.sv
